// ===== rtl/spi_pkg.sv =====
// Shared types, widths and codes of the scan pose interpolator.
package spi_pkg;

  localparam int CNT_W = 7;   // holds a scan count of up to 64
  localparam int T_W   = 49;  // signed difference of two stamps
  localparam int D_W   = 33;  // signed difference of two poses
  localparam int P_W   = T_W + D_W;
  localparam int Q_KEEP = 40;

  localparam logic [1:0] ST_PUBLISHED  = 2'd0;
  localparam logic [1:0] ST_SUPPRESSED = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_NO_POSE    = 2'd3;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_POSE = 1'b1;

  localparam logic CMD_RESULT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic [2:0] CFG_INTERP    = 3'd0;
  localparam logic [2:0] CFG_LIMIT     = 3'd1;
  localparam logic [2:0] CFG_PASS_ALL  = 3'd2;
  localparam logic [2:0] CFG_DIST_GATE = 3'd3;
  localparam logic [2:0] CFG_YAW_GATE  = 3'd4;
  localparam logic [2:0] CFG_TIME_GATE = 3'd5;

  // One word of the queue between front and back. For a finished result x, y
  // and yaw are the result pose; for a flush they are the new pose.
  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [15:0]      tag;
    logic [47:0]      stamp;
    logic [31:0]      x;
    logic [31:0]      y;
    logic [15:0]      yaw;
    logic [CNT_W-1:0] count;
    logic [31:0]      px;
    logic [31:0]      py;
    logic [15:0]      pyaw;
    logic [47:0]      ptime;
  } cmd_t;

  function automatic logic [31:0] axis_fin(logic [31:0] base, logic [P_W-1:0] q,
                                           logic neg);
    logic        neg_f;
    logic        big;
    logic [41:0] mag;
    logic [41:0] sum;
    neg_f = neg && (q[63:0] != 64'd0);
    big   = |q[P_W-1:Q_KEEP];
    mag   = {2'b00, q[Q_KEEP-1:0]};
    sum   = {{10{base[31]}}, base} + (neg_f ? (~mag + 42'd1) : mag);
    if (big) begin
      axis_fin = neg_f ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (!sum[41] && (|sum[40:31])) begin
      axis_fin = 32'h7fff_ffff;
    end else if (sum[41] && !(&sum[40:31])) begin
      axis_fin = 32'h8000_0000;
    end else begin
      axis_fin = sum[31:0];
    end
  endfunction

  function automatic logic [15:0] yaw_fin(logic [15:0] base, logic [P_W-1:0] q,
                                          logic neg);
    yaw_fin = base + (neg ? (~q[15:0] + 16'd1) : q[15:0]);
  endfunction

endpackage

// ===== rtl/spi_fifo.sv =====
// Two-word queue between the front and the back.
module spi_fifo import spi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t pop_cmd
);

  cmd_t       words [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign avail   = (fill != 2'd0);
  assign pop_cmd = words[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      words[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !avail))
    else $error("queue pushed when full or popped when empty");

endmodule

// ===== rtl/spi_front.sv =====
// Front: accepts events, buffers scans, emits results and flush jobs.
module spi_front import spi_pkg::*; #(
  parameter int SCAN_DEPTH = 32,
  parameter int AW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          op,
  input  logic [47:0]   stamp_us,
  input  logic [15:0]   scan_tag,
  input  logic [31:0]   pose_x,
  input  logic [31:0]   pose_y,
  input  logic [15:0]   pose_yaw,
  input  logic          interp_enable,
  input  logic [5:0]    buffer_limit,
  output logic          q_push,
  output cmd_t          q_cmd,
  input  logic          q_full,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_tag,
  output logic [47:0]   rd_time,
  input  logic          flush_done
);

  logic [15:0]      tag_mem  [SCAN_DEPTH];
  logic [47:0]      time_mem [SCAN_DEPTH];
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             have_pose;
  logic [31:0]      prev_x;
  logic [31:0]      prev_y;
  logic [15:0]      prev_yaw;
  logic [47:0]      prev_time;
  logic             accept;
  logic [CNT_W-1:0] lim;
  logic             store_scan;
  logic             do_flush;

  assign in_ready = !busy && !q_full;
  assign accept   = in_valid && in_ready;
  assign lim = ({1'b0, buffer_limit} > CNT_W'(SCAN_DEPTH)) ? CNT_W'(SCAN_DEPTH)
                                                           : {1'b0, buffer_limit};
  assign store_scan = accept && (op == OP_SCAN) && interp_enable && (count < lim);
  assign do_flush   = accept && (op == OP_POSE) && have_pose && interp_enable &&
                      (count != '0);

  always_comb begin
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.tag    = scan_tag;
    q_cmd.stamp  = stamp_us;
    q_cmd.count  = count;
    q_cmd.px     = prev_x;
    q_cmd.py     = prev_y;
    q_cmd.pyaw   = prev_yaw;
    q_cmd.ptime  = prev_time;
    if (accept && (op == OP_SCAN) && !store_scan) begin
      q_push      = 1'b1;
      q_cmd.kind  = CMD_RESULT;
      if (interp_enable) begin
        q_cmd.status = ST_FULL;
      end else if (have_pose) begin
        q_cmd.status = ST_PUBLISHED;
        q_cmd.x      = prev_x;
        q_cmd.y      = prev_y;
        q_cmd.yaw    = prev_yaw;
      end else begin
        q_cmd.status = ST_NO_POSE;
      end
    end else if (do_flush) begin
      q_push     = 1'b1;
      q_cmd.kind = CMD_FLUSH;
      q_cmd.x    = pose_x;
      q_cmd.y    = pose_y;
      q_cmd.yaw  = pose_yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (store_scan) begin
      tag_mem[count[AW-1:0]]  <= scan_tag;
      time_mem[count[AW-1:0]] <= stamp_us;
    end
    rd_tag  <= tag_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      have_pose <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_yaw  <= '0;
      prev_time <= '0;
    end else begin
      if (flush_done) busy <= 1'b0;
      if (store_scan) count <= count + 1'b1;
      if (accept && (op == OP_POSE)) begin
        // hold new words off until the back has read the whole buffer
        if (do_flush) begin
          busy  <= 1'b1;
          count <= '0;
        end else if (have_pose && interp_enable) begin
          count <= '0;
        end
        have_pose <= 1'b1;
        prev_x    <= pose_x;
        prev_y    <= pose_y;
        prev_yaw  <= pose_yaw;
        prev_time <= stamp_us;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SCAN_DEPTH))
    else $error("scan count above buffer depth");

endmodule

// ===== rtl/spi_lane.sv =====
// Serial multiply then restoring divide: |t0*d| / |t1|, one bit a cycle.
module spi_lane import spi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [T_W-1:0] t0,
  input  logic signed [T_W-1:0] t1,
  input  logic signed [D_W-1:0] d,
  output logic                  done,
  output logic [P_W-1:0]        quo,
  output logic                  neg
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MUL  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;

  logic [1:0]     state;
  logic [6:0]     cnt;
  logic [P_W-1:0] mcand;
  logic [D_W-1:0] mplier;
  logic [P_W-1:0] acc;
  logic [T_W-1:0] dv;
  logic [T_W-1:0] rem;
  logic [T_W-1:0] t0_mag;
  logic [T_W-1:0] t1_mag;
  logic [D_W-1:0] d_mag;
  logic [P_W-1:0] add_val;
  logic [T_W:0]   rem_sh;
  logic [T_W:0]   rem_sub;
  logic           fits;

  assign t0_mag  = t0[T_W-1] ? (~t0 + 1'b1) : t0;
  assign t1_mag  = t1[T_W-1] ? (~t1 + 1'b1) : t1;
  assign d_mag   = d[D_W-1] ? (~d + 1'b1) : d;
  assign add_val = acc + (mplier[0] ? mcand : '0);
  assign rem_sh  = {rem, acc[P_W-1]};
  assign fits    = rem_sh >= {1'b0, dv};
  assign rem_sub = rem_sh - {1'b0, dv};
  assign quo     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        L_IDLE: begin
          done <= 1'b0;
          if (start) begin
            mcand  <= {{(P_W-T_W){1'b0}}, t0_mag};
            mplier <= d_mag;
            acc    <= '0;
            dv     <= t1_mag;
            rem    <= '0;
            neg    <= t0[T_W-1] ^ d[D_W-1] ^ t1[T_W-1];
            cnt    <= '0;
            state  <= L_MUL;
          end
        end
        L_MUL: begin
          done   <= 1'b0;
          acc    <= add_val;
          mcand  <= {mcand[P_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[D_W-1:1]};
          if (cnt == 7'(D_W - 1)) begin
            cnt   <= '0;
            state <= L_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        L_DIV: begin
          rem  <= fits ? rem_sub[T_W-1:0] : rem_sh[T_W-1:0];
          acc  <= {acc[P_W-2:0], fits};
          cnt  <= cnt + 1'b1;
          done <= (cnt == 7'(P_W - 1));
          if (cnt == 7'(P_W - 1)) begin
            state <= L_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/spi_back.sv =====
// Back: runs flush jobs through the interpolation lanes and the gate.
module spi_back import spi_pkg::*; #(
  parameter int SCAN_DEPTH = 32,
  parameter int AW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_avail,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic [AW-1:0] rd_addr,
  input  logic [15:0]   rd_tag,
  input  logic [47:0]   rd_time,
  output logic          flush_done,
  input  logic          pass_all,
  input  logic [31:0]   dist_gate,
  input  logic [16:0]   yaw_gate,
  input  logic [48:0]   time_gate,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [15:0]   out_tag,
  output logic [47:0]   out_stamp,
  output logic [31:0]   out_x,
  output logic [31:0]   out_y,
  output logic [15:0]   out_yaw,
  output logic          last
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_READ = 4'd1;
  localparam logic [3:0] B_LOAD = 4'd2;
  localparam logic [3:0] B_RUN  = 4'd3;
  localparam logic [3:0] B_POST = 4'd4;
  localparam logic [3:0] B_DIFF = 4'd5;
  localparam logic [3:0] B_SQ   = 4'd6;
  localparam logic [3:0] B_GATE = 4'd7;
  localparam logic [3:0] B_EMIT = 4'd8;

  logic [3:0]            state;
  logic [CNT_W-1:0]      idx;
  cmd_t                  job;
  logic signed [T_W-1:0] t1;
  logic signed [T_W-1:0] t0;
  logic                  t1_zero;
  logic                  is_flush;
  logic [15:0]           cur_tag;
  logic [47:0]           cur_time;
  logic [31:0]           rx;
  logic [31:0]           ry;
  logic [15:0]           ryaw;
  logic [31:0]           ex;
  logic [31:0]           ey;
  logic [16:0]           yaw_mag;
  logic signed [T_W-1:0] tdiff;
  logic [63:0]           sx;
  logic [63:0]           sy;
  logic [61:0]           g2;
  logic                  have_published;
  logic [31:0]           pub_x;
  logic [31:0]           pub_y;
  logic [15:0]           pub_yaw;
  logic [47:0]           pub_time;
  logic [1:0]            s_status;
  logic                  lane_start;
  logic [2:0]            lane_done;
  logic [P_W-1:0]        quo [3];
  logic [2:0]            lane_neg;
  logic signed [D_W-1:0] dx;
  logic signed [D_W-1:0] dy;
  logic signed [D_W-1:0] dyaw;
  logic [15:0]           yaw_step;
  logic [32:0]           x_diff;
  logic [32:0]           y_diff;
  logic [15:0]           yaw_diff;
  logic                  open_gate;
  logic                  slot_free;
  logic                  final_word;

  assign rd_addr    = idx[AW-1:0];
  // scan offset from the previous pose, taken by the lanes as they start
  assign t0         = {1'b0, rd_time} - {1'b0, job.ptime};
  assign dx         = {job.x[31], job.x} - {job.px[31], job.px};
  assign dy         = {job.y[31], job.y} - {job.py[31], job.py};
  assign yaw_step   = job.yaw - job.pyaw;
  assign dyaw       = {{(D_W-16){yaw_step[15]}}, yaw_step};
  assign x_diff     = {rx[31], rx} - {pub_x[31], pub_x};
  assign y_diff     = {ry[31], ry} - {pub_y[31], pub_y};
  assign yaw_diff   = ryaw - pub_yaw;
  assign slot_free  = !out_valid || out_ready;
  assign final_word = !is_flush || (idx + 1'b1 == job.count);
  assign q_pop      = (state == B_IDLE) && q_avail;
  assign lane_start = (state == B_LOAD) && !t1_zero;
  assign flush_done = (state == B_EMIT) && slot_free && is_flush && final_word;

  spi_lane u_lane_x (.clk, .rst, .start(lane_start), .t0, .t1, .d(dx),
    .done(lane_done[0]), .quo(quo[0]), .neg(lane_neg[0]));
  spi_lane u_lane_y (.clk, .rst, .start(lane_start), .t0, .t1, .d(dy),
    .done(lane_done[1]), .quo(quo[1]), .neg(lane_neg[1]));
  spi_lane u_lane_yaw (.clk, .rst, .start(lane_start), .t0, .t1, .d(dyaw),
    .done(lane_done[2]), .quo(quo[2]), .neg(lane_neg[2]));

  always_comb begin
    open_gate = pass_all || !have_published;
    if (!dist_gate[31] && (({1'b0, sx} + {1'b0, sy}) >= 65'(g2))) open_gate = 1'b1;
    if (!yaw_gate[16] && (yaw_mag >= yaw_gate)) open_gate = 1'b1;
    if (!time_gate[48] && (tdiff >= $signed(time_gate))) open_gate = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      idx            <= '0;
      is_flush       <= 1'b0;
      out_valid      <= 1'b0;
      have_published <= 1'b0;
      pub_x          <= '0;
      pub_y          <= '0;
      pub_yaw        <= '0;
      pub_time       <= '0;
    end else begin
      if (out_valid && out_ready && (state != B_EMIT)) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_avail) begin
            job      <= q_cmd;
            idx      <= '0;
            t1       <= {1'b0, q_cmd.stamp} - {1'b0, q_cmd.ptime};
            t1_zero  <= (q_cmd.stamp == q_cmd.ptime);
            cur_tag  <= q_cmd.tag;
            cur_time <= q_cmd.stamp;
            rx       <= q_cmd.x;
            ry       <= q_cmd.y;
            ryaw     <= q_cmd.yaw;
            s_status <= q_cmd.status;
            if (q_cmd.kind == CMD_FLUSH) begin
              is_flush <= 1'b1;
              state    <= B_READ;
            end else begin
              is_flush <= 1'b0;
              state    <= B_EMIT;
            end
          end
        end
        B_READ: state <= B_LOAD;
        B_LOAD: begin
          cur_tag  <= rd_tag;
          cur_time <= rd_time;
          state    <= t1_zero ? B_POST : B_RUN;
        end
        B_RUN: begin
          if (lane_done[0]) state <= B_POST;
        end
        B_POST: begin
          if (t1_zero) begin
            rx   <= job.px;
            ry   <= job.py;
            ryaw <= job.pyaw;
          end else begin
            rx   <= axis_fin(job.px, quo[0], lane_neg[0]);
            ry   <= axis_fin(job.py, quo[1], lane_neg[1]);
            ryaw <= yaw_fin(job.pyaw, quo[2], lane_neg[2]);
          end
          state <= B_DIFF;
        end
        B_DIFF: begin
          ex      <= x_diff[32] ? 32'(~x_diff + 1'b1) : x_diff[31:0];
          ey      <= y_diff[32] ? 32'(~y_diff + 1'b1) : y_diff[31:0];
          yaw_mag <= yaw_diff[15] ? (~{1'b1, yaw_diff} + 1'b1) : {1'b0, yaw_diff};
          tdiff   <= {1'b0, cur_time} - {1'b0, pub_time};
          state   <= B_SQ;
        end
        B_SQ: begin
          sx    <= ex * ex;
          sy    <= ey * ey;
          g2    <= dist_gate[30:0] * dist_gate[30:0];
          state <= B_GATE;
        end
        B_GATE: begin
          if (open_gate) begin
            s_status       <= ST_PUBLISHED;
            have_published <= 1'b1;
            pub_x          <= rx;
            pub_y          <= ry;
            pub_yaw        <= ryaw;
            pub_time       <= cur_time;
          end else begin
            s_status <= ST_SUPPRESSED;
          end
          state <= B_EMIT;
        end
        B_EMIT: begin
          // hold until the output register frees up
          if (slot_free) begin
            out_valid <= 1'b1;
            status    <= s_status;
            out_tag   <= cur_tag;
            out_stamp <= cur_time;
            out_x     <= rx;
            out_y     <= ry;
            out_yaw   <= ryaw;
            last      <= final_word;
            if (final_word) begin
              state <= B_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= B_READ;
            end
          end else begin
            out_valid <= out_valid;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ) |-> (idx < job.count))
    else $error("buffer read past the flushed scan count");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (lane_done[0] == lane_done[1]) && (lane_done[0] == lane_done[2]))
    else $error("interpolation lanes out of step");

endmodule

// ===== rtl/scan_pose_interpolator.sv =====
// Top level of the scan pose interpolator: config registers, front, queue, back.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_ready   op, stamp_us, scan_tag, pose_x/y/yaw
//   out      output     out_valid / out_ready status, out_tag, out_stamp, out_x/y/yaw, last
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A pose that flushes buffered scans runs each one through 2 buffer read steps, the
// three lanes' serial 33-step multiply and 82-step divide plus one step to see them
// finish, then 5 gate and output steps; a zero span skips the lanes. The front takes
// no word while a flush is running. rst is synchronous and clears all control state
// and the gate history. A stalled out channel holds the back; the front keeps going
// until the two-word queue fills.
module scan_pose_interpolator import spi_pkg::*; #(
  parameter int SCAN_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [47:0] stamp_us,
  input  logic [15:0] scan_tag,
  input  logic [31:0] pose_x,
  input  logic [31:0] pose_y,
  input  logic [15:0] pose_yaw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] out_tag,
  output logic [47:0] out_stamp,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [15:0] out_yaw,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [48:0] cfg_data
);

  localparam int AW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;

  logic          interp_enable;
  logic [5:0]    buffer_limit;
  logic          pass_all;
  logic [31:0]   dist_gate;
  logic [16:0]   yaw_gate;
  logic [48:0]   time_gate;
  logic          q_push;
  cmd_t          push_cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_avail;
  cmd_t          pop_cmd;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_tag;
  logic [47:0]   rd_time;
  logic          flush_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_enable <= 1'b1;
      buffer_limit  <= 6'd32;
      pass_all      <= 1'b1;
      dist_gate     <= '1;
      yaw_gate      <= '1;
      time_gate     <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INTERP:    interp_enable <= cfg_data[0];
        CFG_LIMIT:     buffer_limit  <= cfg_data[5:0];
        CFG_PASS_ALL:  pass_all      <= cfg_data[0];
        CFG_DIST_GATE: dist_gate     <= cfg_data[31:0];
        CFG_YAW_GATE:  yaw_gate      <= cfg_data[16:0];
        CFG_TIME_GATE: time_gate     <= cfg_data;
        default: ;
      endcase
    end
  end

  spi_front #(.SCAN_DEPTH(SCAN_DEPTH), .AW(AW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .stamp_us, .scan_tag,
    .pose_x, .pose_y, .pose_yaw, .interp_enable, .buffer_limit,
    .q_push, .q_cmd(push_cmd), .q_full, .rd_addr, .rd_tag, .rd_time, .flush_done
  );

  spi_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_cmd, .full(q_full),
    .pop(q_pop), .avail(q_avail), .pop_cmd
  );

  spi_back #(.SCAN_DEPTH(SCAN_DEPTH), .AW(AW)) u_back (
    .clk, .rst, .q_avail, .q_cmd(pop_cmd), .q_pop, .rd_addr, .rd_tag, .rd_time,
    .flush_done, .pass_all, .dist_gate, .yaw_gate, .time_gate,
    .out_valid, .out_ready, .status, .out_tag, .out_stamp, .out_x, .out_y,
    .out_yaw, .last
  );

endmodule
